@@ rtl/core/brdc_pkg.sv @@
// Package with shared types, constants and datapath operation codes.
package brdc_pkg;

    localparam int VW = 32;
    localparam int FB = 16;

    localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;
    localparam logic [31:0] RAD2DEG_Q24 = 32'd961263669;
    localparam logic [31:0] RADIUS_Q32  = 32'd214748365;

    localparam logic [2:0] ADDR_MODE  = 3'd0;
    localparam logic [2:0] ADDR_SFF   = 3'd1;
    localparam logic [2:0] ADDR_AFF   = 3'd2;
    localparam logic [2:0] ADDR_SPID  = 3'd3;
    localparam logic [2:0] ADDR_APID  = 3'd4;
    localparam logic [2:0] ADDR_LQR   = 3'd5;
    localparam logic [2:0] ADDR_S2D   = 3'd6;
    localparam logic [2:0] ADDR_ALIM  = 3'd7;

    // Operation codes sequenced by the controller; most select operands for the shared scale unit.
    typedef enum logic [5:0] {
        OP_FA0, OP_FA1, OP_FS0, OP_FS1, OP_FDONE,
        OP_L_SPD, OP_L_A, OP_L_LIN, OP_L_LC, OP_L_AC1, OP_L_AC2,
        OP_L_GC1, OP_L_GC2, OP_L_T1, OP_L_T2, OP_L_DRV,
        OP_S_RATE, OP_S_ERR, OP_S_INT, OP_S_DER, OP_S_P, OP_S_I, OP_S_D, OP_S_OUT,
        OP_A_ERR, OP_A_INT, OP_A_DER, OP_A_P, OP_A_I, OP_A_D, OP_A_OUT,
        OP_OPEN, OP_FINAL, OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic kind;
        logic [2:0] mode;
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [16:0] sff;
        logic [16:0] aff;
        logic [47:0] spid;
        logic [47:0] apid;
        logic [47:0] lqr;
        logic [30:0] s2d;
        logic [30:0] alim;
    } t_cfg;

endpackage

@@ rtl/core/brdc_scale.sv @@
// Multi-cycle unit computing sat(trunc(a*b*2^up/2^down/d)).
module brdc_scale (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [63:0]     i_a,
    input  logic signed [63:0]     i_b,
    input  logic [5:0]             i_up,
    input  logic [5:0]             i_down,
    input  logic [31:0]            i_d,
    output logic                   o_busy,
    output logic signed [31:0]     o_q
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SHIFT, S_DIV, S_SAT} t_sst;
    t_sst r_st, n_st;
    logic r_neg;
    logic [63:0] r_ua, r_ub;
    logic [127:0] r_acc, r_num, r_quo;
    logic [63:0] r_rem;
    logic [31:0] r_d;
    logic [5:0] r_up, r_down;
    logic [6:0] r_cnt;
    logic signed [31:0] r_q;
    logic [64:0] w_trial;
    logic [63:0] w_mag;

    assign o_busy = (r_st != S_IDLE);
    assign o_q = r_q;
    assign w_trial = {r_rem, r_num[127]} - {33'd0, r_d};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_start) n_st = S_MUL;
            S_MUL:   if (r_cnt == 7'd3) n_st = S_SHIFT;
            S_SHIFT: n_st = (r_d > 32'd1) ? S_DIV : S_SAT;
            S_DIV:   if (r_cnt == 7'd127) n_st = S_SAT;
            S_SAT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign w_mag = (r_quo[127:64] != 64'd0 || r_quo[63:0] > 64'h8000_0000)
                   ? 64'h8000_0000 : r_quo[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_neg  <= i_a[63] ^ i_b[63];
                        r_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
                        r_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
                        r_up   <= i_up;
                        r_down <= i_down;
                        r_d    <= i_d;
                        r_acc  <= '0;
                    end
                end
                S_MUL: begin
                    r_acc <= r_acc + ((128'(r_ua[r_cnt[1]*32 +: 32]) *
                             128'(r_ub[r_cnt[0]*32 +: 32])) <<
                             (7'(r_cnt[1] + r_cnt[0]) * 7'd32));
                    r_cnt <= (r_cnt == 7'd3) ? 7'd0 : r_cnt + 7'd1;
                end
                S_SHIFT: begin
                    r_num <= (r_acc << r_up) >> r_down;
                    r_quo <= (r_acc << r_up) >> r_down;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    if (!w_trial[64]) begin
                        r_rem <= w_trial[63:0];
                        r_quo <= {r_quo[126:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_num[127]};
                        r_quo <= {r_quo[126:0], 1'b0};
                    end
                    r_num <= {r_num[126:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                end
                S_SAT: begin
                    if (r_neg) r_q <= 32'(-w_mag);
                    else if (w_mag > 64'h7FFF_FFFF) r_q <= 32'h7FFF_FFFF;
                    else r_q <= 32'(w_mag);
                end
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/core/brdc_datapath.sv @@
// Datapath: state registers, operand selection and the shared scale unit.
module brdc_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  brdc_pkg::t_cmd          i_cmd,
    input  brdc_pkg::t_cfg          i_cfg,
    input  logic [184:0]            i_item,
    output brdc_pkg::t_status       o_status,
    output logic signed [31:0]      o_left,
    output logic signed [31:0]      o_right
);
    logic r_kind;
    logic signed [31:0] r_ang, r_rate, r_spd, r_thr, r_rot;
    logic [23:0] r_per;
    logic signed [31:0] r_fa, r_fs, r_ses, r_lse, r_aes, r_lae;
    logic signed [31:0] r_t0, r_t1, r_t2, r_err, r_tgt;
    logic signed [31:0] r_left, r_right;

    logic               w_start;
    logic signed [63:0] w_a, w_b;
    logic [5:0]         w_up, w_down;
    logic [31:0]        w_d;
    logic               w_busy;
    logic signed [31:0] w_q;
    logic [31:0]        w_s2d, w_per32;
    logic signed [31:0] w_lim;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -33'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return sat33(33'(a) + 33'(b));
    endfunction

    function automatic logic signed [31:0] sub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return sat33(33'(a) - 33'(b));
    endfunction

    // Saturated -a - b; the negation of the most negative value needs the extra bits.
    function automatic logic signed [31:0] nsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [33:0] v;
        v = -34'(a) - 34'(b);
        if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clip(input logic signed [31:0] v,
                                                input logic signed [31:0] m);
        if (v > m) return m;
        if (v < -m) return -m;
        return v;
    endfunction

    function automatic logic signed [63:0] g16(input logic [47:0] p, input int s);
        return 64'(signed'(p[s*16 +: 16]));
    endfunction

    assign w_s2d   = (i_cfg.s2d == 31'd0) ? 32'd1 : {1'b0, i_cfg.s2d};
    assign w_per32 = {8'd0, r_per};
    assign w_lim   = {1'b0, i_cfg.alim};

    assign o_status = '{busy: w_busy, kind: r_kind, mode: i_cfg.mode};
    assign o_left   = r_left;
    assign o_right  = r_right;
    assign w_start  = i_cmd.start;

    always_comb begin
        w_a = '0; w_b = 64'sd1; w_up = '0; w_down = '0; w_d = 32'd1;
        case (i_cmd.op)
            brdc_pkg::OP_FA0: begin
                w_a = 64'(r_ang); w_b = 64'({15'd0, i_cfg.aff}); w_down = 6'd16;
            end
            brdc_pkg::OP_FA1: begin
                w_a = 64'(r_fa); w_b = 64'sd65536 - 64'({15'd0, i_cfg.aff});
                w_down = 6'd16;
            end
            brdc_pkg::OP_FS0: begin
                w_a = 64'(r_spd); w_b = 64'({15'd0, i_cfg.sff}); w_down = 6'd16;
            end
            brdc_pkg::OP_FS1: begin
                w_a = 64'(r_fs); w_b = 64'sd65536 - 64'({15'd0, i_cfg.sff});
                w_down = 6'd16;
            end
            brdc_pkg::OP_L_SPD: begin
                w_a = 64'(r_fs); w_b = 64'({32'd0, w_s2d}); w_down = 6'(brdc_pkg::FB);
            end
            brdc_pkg::OP_L_A: begin
                w_a = 64'(r_t0); w_b = 64'({32'd0, brdc_pkg::DEG2RAD_Q32}); w_down = 6'd32;
            end
            brdc_pkg::OP_L_LIN: begin
                w_a = 64'(r_t0); w_b = 64'({32'd0, brdc_pkg::RADIUS_Q32}); w_down = 6'd32;
            end
            brdc_pkg::OP_L_LC: begin
                w_a = g16(i_cfg.lqr, 0); w_b = 64'(sub(r_thr, r_t0)); w_down = 6'd8;
            end
            brdc_pkg::OP_L_AC1: begin
                w_a = g16(i_cfg.lqr, 1); w_b = 64'(r_rate); w_down = 6'd8;
            end
            brdc_pkg::OP_L_AC2, brdc_pkg::OP_L_GC2: begin
                w_a = 64'(r_t2); w_b = 64'({32'd0, brdc_pkg::DEG2RAD_Q32}); w_down = 6'd32;
            end
            brdc_pkg::OP_L_GC1: begin
                w_a = g16(i_cfg.lqr, 2); w_b = 64'(r_fa); w_down = 6'd8;
            end
            brdc_pkg::OP_L_T1: begin
                w_a = 64'(r_t0); w_b = 64'(w_per32); w_down = 6'd24;
            end
            brdc_pkg::OP_L_T2: begin
                w_a = 64'(r_t0); w_b = 64'({32'd0, brdc_pkg::RAD2DEG_Q24}); w_down = 6'd24;
            end
            brdc_pkg::OP_L_DRV: begin
                w_a = 64'(r_t0); w_up = 6'(brdc_pkg::FB); w_d = w_s2d;
            end
            brdc_pkg::OP_S_RATE: begin
                w_a = 64'(r_rate); w_up = 6'(brdc_pkg::FB); w_d = w_s2d;
            end
            brdc_pkg::OP_S_INT, brdc_pkg::OP_A_INT: begin
                w_a = 64'(r_err); w_b = 64'(w_per32); w_down = 6'd24;
            end
            brdc_pkg::OP_S_DER: begin
                w_a = 64'(sub(r_err, r_lse)); w_up = 6'd24; w_d = w_per32;
            end
            brdc_pkg::OP_A_DER: begin
                w_a = 64'(sub(r_err, r_lae)); w_up = 6'd24; w_d = w_per32;
            end
            brdc_pkg::OP_S_P: begin
                w_a = g16(i_cfg.spid, 0); w_b = 64'(r_err); w_down = 6'd8;
            end
            brdc_pkg::OP_S_I: begin
                w_a = g16(i_cfg.spid, 1); w_b = 64'(r_ses); w_down = 6'd8;
            end
            brdc_pkg::OP_S_D: begin
                w_a = g16(i_cfg.spid, 2); w_b = 64'(r_t1); w_down = 6'd8;
            end
            brdc_pkg::OP_A_P: begin
                w_a = g16(i_cfg.apid, 0); w_b = 64'(r_err); w_down = 6'd8;
            end
            brdc_pkg::OP_A_I: begin
                w_a = g16(i_cfg.apid, 1); w_b = 64'(r_aes); w_down = 6'd8;
            end
            brdc_pkg::OP_A_D: begin
                w_a = g16(i_cfg.apid, 2); w_b = 64'(r_t1); w_down = 6'd8;
            end
            default: ;
        endcase
    end

    brdc_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_a), .i_b(w_b), .i_up(w_up), .i_down(w_down), .i_d(w_d),
        .o_busy(w_busy), .o_q(w_q)
    );

    // Result write-back happens when the controller sets load, once the scale unit is no
    // longer busy or at once for other ops; the op field then names the finishing operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa <= '0; r_fs <= '0; r_ses <= '0; r_lse <= '0; r_aes <= '0; r_lae <= '0;
            r_kind <= 1'b0;
        end else if (i_cmd.op == brdc_pkg::OP_OPEN && i_cmd.load) begin
            r_kind <= i_item[0];
            r_ang  <= i_item[32:1];
            r_rate <= i_item[64:33];
            r_spd  <= i_item[96:65];
            r_thr  <= clip(i_item[128:97], ONE);
            r_rot  <= clip(i_item[160:129], ONE);
            r_per  <= (i_item[184:161] == 24'd0) ? 24'd1 : i_item[184:161];
            r_tgt  <= '0;
        end else if (i_cmd.load) begin
            case (i_cmd.op)
                brdc_pkg::OP_CLEAR: begin
                    r_ses <= '0; r_lse <= '0; r_aes <= '0; r_lae <= '0;
                end
                brdc_pkg::OP_FA0, brdc_pkg::OP_FS0: r_t0 <= w_q;
                brdc_pkg::OP_FA1: r_fa <= add(r_t0, w_q);
                brdc_pkg::OP_FS1: r_fs <= add(r_t0, w_q);
                brdc_pkg::OP_L_SPD: r_t0 <= nsub(w_q, r_rate);
                brdc_pkg::OP_L_A, brdc_pkg::OP_L_LIN, brdc_pkg::OP_L_T1,
                brdc_pkg::OP_L_T2: r_t0 <= w_q;
                brdc_pkg::OP_L_LC: r_t1 <= w_q;
                brdc_pkg::OP_L_AC1, brdc_pkg::OP_L_GC1: r_t2 <= w_q;
                brdc_pkg::OP_L_AC2: r_t1 <= sub(r_t1, w_q);
                brdc_pkg::OP_L_GC2: r_t0 <= sub(r_t1, w_q);
                brdc_pkg::OP_L_DRV, brdc_pkg::OP_S_RATE: r_t0 <= w_q;
                brdc_pkg::OP_S_ERR: r_err <= sub(r_thr, nsub(r_fs, r_t0));
                brdc_pkg::OP_S_INT: begin
                    if (add(r_ses, w_q) > w_lim || add(r_ses, w_q) < -w_lim) r_ses <= '0;
                    else r_ses <= add(r_ses, w_q);
                end
                brdc_pkg::OP_A_INT: begin
                    if (add(r_aes, w_q) > ONE || add(r_aes, w_q) < -ONE) r_aes <= '0;
                    else r_aes <= add(r_aes, w_q);
                end
                brdc_pkg::OP_S_DER: begin r_t1 <= w_q; r_lse <= r_err; end
                brdc_pkg::OP_A_DER: begin r_t1 <= w_q; r_lae <= r_err; end
                brdc_pkg::OP_S_P, brdc_pkg::OP_A_P: r_t2 <= w_q;
                brdc_pkg::OP_S_I, brdc_pkg::OP_A_I: r_t2 <= add(r_t2, w_q);
                brdc_pkg::OP_S_D: r_tgt <= clip(add(r_t2, w_q), w_lim);
                brdc_pkg::OP_A_D: r_t0 <= clip(add(r_t2, w_q), ONE);
                brdc_pkg::OP_A_ERR: r_err <= sub(r_tgt, r_fa);
                brdc_pkg::OP_FINAL: begin
                    if (!i_cfg.mode[0]) begin
                        r_left  <= clip(add(r_thr, r_rot), ONE);
                        r_right <= clip(sub(r_thr, r_rot), ONE);
                    end else begin
                        r_left  <= add(add(r_fs, r_t0), r_rot);
                        r_right <= sub(add(r_fs, r_t0), r_rot);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/core/brdc_ctrl.sv @@
// Controller state machine sequencing the datapath operations.
module brdc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  brdc_pkg::t_status  i_status,
    output brdc_pkg::t_cmd     o_cmd
);
    brdc_pkg::t_state r_st, n_st;
    brdc_pkg::t_op r_op, n_op;
    logic w_mul;

    // Ops that use the scale unit; others update registers directly or only advance the sequence.
    always_comb begin
        case (r_op)
            brdc_pkg::OP_FDONE, brdc_pkg::OP_S_ERR, brdc_pkg::OP_A_ERR,
            brdc_pkg::OP_OPEN, brdc_pkg::OP_FINAL, brdc_pkg::OP_CLEAR,
            brdc_pkg::OP_S_OUT, brdc_pkg::OP_A_OUT: w_mul = 1'b0;
            default: w_mul = 1'b1;
        endcase
    end

    // Successor of the current op.
    always_comb begin
        n_op = r_op;
        case (r_op)
            brdc_pkg::OP_OPEN:
                n_op = i_status.kind ? brdc_pkg::OP_CLEAR :
                       (i_status.mode[0] ? brdc_pkg::OP_FA0 : brdc_pkg::OP_FINAL);
            brdc_pkg::OP_FA0:  n_op = brdc_pkg::OP_FA1;
            brdc_pkg::OP_FA1:  n_op = brdc_pkg::OP_FS0;
            brdc_pkg::OP_FS0:  n_op = brdc_pkg::OP_FS1;
            brdc_pkg::OP_FS1:  n_op = brdc_pkg::OP_FDONE;
            brdc_pkg::OP_FDONE:
                n_op = i_status.mode[1] ? brdc_pkg::OP_L_SPD :
                       (i_status.mode[2] ? brdc_pkg::OP_S_RATE : brdc_pkg::OP_A_ERR);
            brdc_pkg::OP_L_SPD: n_op = brdc_pkg::OP_L_A;
            brdc_pkg::OP_L_A:   n_op = brdc_pkg::OP_L_LIN;
            brdc_pkg::OP_L_LIN: n_op = brdc_pkg::OP_L_LC;
            brdc_pkg::OP_L_LC:  n_op = brdc_pkg::OP_L_AC1;
            brdc_pkg::OP_L_AC1: n_op = brdc_pkg::OP_L_AC2;
            brdc_pkg::OP_L_AC2: n_op = brdc_pkg::OP_L_GC1;
            brdc_pkg::OP_L_GC1: n_op = brdc_pkg::OP_L_GC2;
            brdc_pkg::OP_L_GC2: n_op = brdc_pkg::OP_L_T1;
            brdc_pkg::OP_L_T1:  n_op = brdc_pkg::OP_L_T2;
            brdc_pkg::OP_L_T2:  n_op = brdc_pkg::OP_L_DRV;
            brdc_pkg::OP_L_DRV: n_op = brdc_pkg::OP_FINAL;
            brdc_pkg::OP_S_RATE: n_op = brdc_pkg::OP_S_ERR;
            brdc_pkg::OP_S_ERR: n_op = brdc_pkg::OP_S_INT;
            brdc_pkg::OP_S_INT: n_op = brdc_pkg::OP_S_DER;
            brdc_pkg::OP_S_DER: n_op = brdc_pkg::OP_S_P;
            brdc_pkg::OP_S_P:   n_op = brdc_pkg::OP_S_I;
            brdc_pkg::OP_S_I:   n_op = brdc_pkg::OP_S_D;
            brdc_pkg::OP_S_D:   n_op = brdc_pkg::OP_S_OUT;
            brdc_pkg::OP_S_OUT: n_op = brdc_pkg::OP_A_ERR;
            brdc_pkg::OP_A_ERR: n_op = brdc_pkg::OP_A_INT;
            brdc_pkg::OP_A_INT: n_op = brdc_pkg::OP_A_DER;
            brdc_pkg::OP_A_DER: n_op = brdc_pkg::OP_A_P;
            brdc_pkg::OP_A_P:   n_op = brdc_pkg::OP_A_I;
            brdc_pkg::OP_A_I:   n_op = brdc_pkg::OP_A_D;
            brdc_pkg::OP_A_D:   n_op = brdc_pkg::OP_A_OUT;
            brdc_pkg::OP_A_OUT: n_op = brdc_pkg::OP_FINAL;
            default:            n_op = brdc_pkg::OP_OPEN;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            brdc_pkg::ST_IDLE:  if (i_in_valid) n_st = brdc_pkg::ST_ISSUE;
            brdc_pkg::ST_ISSUE: begin
                if (r_op == brdc_pkg::OP_FINAL) n_st = brdc_pkg::ST_OUT;
                else if (r_op == brdc_pkg::OP_CLEAR) n_st = brdc_pkg::ST_IDLE;
                else if (w_mul) n_st = brdc_pkg::ST_WAIT;
            end
            brdc_pkg::ST_WAIT:  if (!i_status.busy) n_st = brdc_pkg::ST_ISSUE;
            brdc_pkg::ST_OUT:   if (i_out_ready) n_st = brdc_pkg::ST_IDLE;
            default:            n_st = brdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '{load: 1'b0, start: 1'b0, op: r_op};
        unique case (r_st)
            brdc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd = '{load: i_in_valid, start: 1'b0, op: brdc_pkg::OP_OPEN};
            end
            brdc_pkg::ST_ISSUE: begin
                o_cmd.start = w_mul;
                o_cmd.load  = !w_mul && (r_op != brdc_pkg::OP_OPEN);
            end
            brdc_pkg::ST_WAIT: o_cmd.load = !i_status.busy;
            brdc_pkg::ST_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= brdc_pkg::ST_IDLE;
            r_op <= brdc_pkg::OP_OPEN;
        end else begin
            r_st <= n_st;
            if (r_st == brdc_pkg::ST_IDLE) r_op <= brdc_pkg::OP_OPEN;
            else if ((r_st == brdc_pkg::ST_ISSUE && !w_mul) ||
                     (r_st == brdc_pkg::ST_WAIT && !i_status.busy))
                r_op <= n_op;
        end
    end
endmodule

@@ rtl/core/balance_robot_drive_controller_top.sv @@
// Top level of the balancing drive controller with APB register file.
// The controller takes one transaction on the slave stream: tuser is the item
// kind (0 control step, 1 clear), tdata carries the measurements and commands.
// A control step yields one transaction on the master stream with the left
// and right motor speeds; a clear item zeroes the PID memory and yields none.
// One item is worked at a time. Its multiply and divide operations go in sequence
// through one shared scale unit (four 32x32 partial products, then a 128-step
// restoring divide when the divisor is above one). With balancing off the
// speeds come straight from throttle and turn; otherwise the filters and then
// the LQR or PID path run first. A new item is taken the cycle after the result
// has been delivered, or once a clear item has been worked.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this.
// Reset restores the register defaults and zeroes all filter and PID state.
// When the receiver stalls, the result holds on the master stream and no new
// item is taken until it has been delivered.
module balance_robot_drive_controller_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [191:0]  s_axis_tdata,   // tilt_angle, tilt_rate, wheel_speed, throttle, turn, loop_period
    input  logic          s_axis_tuser,   // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,   // left_speed, right_speed
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    brdc_pkg::t_cfg r_cfg;
    brdc_pkg::t_cmd w_cmd;
    brdc_pkg::t_status w_status;
    logic signed [31:0] w_left, w_right;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: 3'd7, sff: 17'd65536, aff: 17'd65536, spid: 48'd256,
                       apid: 48'd256, lqr: 48'd0, s2d: 31'd65536, alim: 31'd1966080};
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                brdc_pkg::ADDR_MODE: r_cfg.mode <= pwdata[2:0];
                brdc_pkg::ADDR_SFF:  r_cfg.sff  <= pwdata[16:0];
                brdc_pkg::ADDR_AFF:  r_cfg.aff  <= pwdata[16:0];
                brdc_pkg::ADDR_SPID: r_cfg.spid <= pwdata[47:0];
                brdc_pkg::ADDR_APID: r_cfg.apid <= pwdata[47:0];
                brdc_pkg::ADDR_LQR:  r_cfg.lqr  <= pwdata[47:0];
                brdc_pkg::ADDR_S2D:  r_cfg.s2d  <= pwdata[30:0];
                brdc_pkg::ADDR_ALIM: r_cfg.alim <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            brdc_pkg::ADDR_MODE: prdata = {61'd0, r_cfg.mode};
            brdc_pkg::ADDR_SFF:  prdata = {47'd0, r_cfg.sff};
            brdc_pkg::ADDR_AFF:  prdata = {47'd0, r_cfg.aff};
            brdc_pkg::ADDR_SPID: prdata = {16'd0, r_cfg.spid};
            brdc_pkg::ADDR_APID: prdata = {16'd0, r_cfg.apid};
            brdc_pkg::ADDR_LQR:  prdata = {16'd0, r_cfg.lqr};
            brdc_pkg::ADDR_S2D:  prdata = {33'd0, r_cfg.s2d};
            brdc_pkg::ADDR_ALIM: prdata = {33'd0, r_cfg.alim};
            default:             prdata = '0;
        endcase
    end

    brdc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    brdc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_cfg(r_cfg),
        .i_item({s_axis_tdata[183:0], s_axis_tuser}),
        .o_status(w_status), .o_left(w_left), .o_right(w_right)
    );

    assign m_axis_tdata = {w_right, w_left};
endmodule
